// ===== design/ibq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ibq_pkg;

  // Fixed widths and term count of the filter
  localparam int HIST_W     = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int MAC_TERMS  = 5;

  // Defaults for the top level parameters
  localparam int DEF_SAMPLE_WIDTH = 8;
  localparam int DEF_COEF_WIDTH   = 13;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_B0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_B1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_B2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_A0 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_A1 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_A2 = 3'd5;

  // Coefficient values after reset
  localparam int RST_B0 = 1;
  localparam int RST_B1 = 2;
  localparam int RST_B2 = 1;
  localparam int RST_A0 = 1059;
  localparam int RST_A1 = -2023;
  localparam int RST_A2 = 968;

  // Product term picked for the shared multiplier
  typedef enum logic [2:0] {
    TERM_B0,
    TERM_B1,
    TERM_B2,
    TERM_A1,
    TERM_A2
  } term_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic  load_x;
    logic  clr_acc;
    logic  mul;
    term_e term;
    logic  acc;
    logic  div_load;
    logic  div_step;
    logic  emit;
  } cmd_t;

endpackage

`default_nettype wire

// ===== design/ibq_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ibq_datapath #(
  parameter int SAMPLE_WIDTH = ibq_pkg::DEF_SAMPLE_WIDTH,
  parameter int COEF_WIDTH   = ibq_pkg::DEF_COEF_WIDTH
) (
  input  wire                                    clk_i,
  input  wire                                    rst_ni,
  input  wire                                    cfg_we_i,
  input  wire        [ibq_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire        [COEF_WIDTH-1:0]            cfg_data_i,
  input  wire signed [SAMPLE_WIDTH-1:0]          sample_in_i,
  input  wire ibq_pkg::cmd_t                     cmd_i,
  output logic signed [SAMPLE_WIDTH-1:0]         sample_out_o
);

  localparam int HW     = ibq_pkg::HIST_W;
  localparam int A0_W   = COEF_WIDTH - 1;
  localparam int PROD_W = COEF_WIDTH + HW;
  localparam int ACC_W  = COEF_WIDTH + HW + 3;

  localparam logic [ACC_W-1:0] Y_POS_MAX = ACC_W'((64'd1 << (HW - 1)) - 64'd1);
  localparam logic [ACC_W-1:0] Y_NEG_MAX = ACC_W'(64'd1 << (HW - 1));
  localparam logic [ACC_W-1:0] S_POS_MAX = ACC_W'((64'd1 << (SAMPLE_WIDTH - 1)) - 64'd1);
  localparam logic [ACC_W-1:0] S_NEG_MAX = ACC_W'(64'd1 << (SAMPLE_WIDTH - 1));

  logic signed [COEF_WIDTH-1:0]   b0_q, b1_q, b2_q, a1_q, a2_q;
  logic        [A0_W-1:0]         a0_q;
  logic signed [SAMPLE_WIDTH-1:0] x_q, xh1_q, xh2_q;
  logic signed [HW-1:0]           yh1_q, yh2_q;

  logic signed [COEF_WIDTH-1:0]   op_coef;
  logic signed [HW-1:0]           op_data;
  logic                           op_sub;
  logic signed [PROD_W-1:0]       prod_d, prod_q;
  logic                           prod_sub_q;
  logic signed [ACC_W-1:0]        acc_q, acc_d;

  logic        [A0_W-1:0]         div_v;
  logic        [ACC_W-1:0]        dq_q;
  logic        [A0_W-1:0]         rem_q;
  logic                           neg_q;
  logic        [A0_W:0]           trial;
  logic        [A0_W+1:0]         diff;
  logic                           qbit;

  logic        [HW-1:0]           y_sat;
  logic        [SAMPLE_WIDTH-1:0] s_sat;

  // Coefficient registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b0_q <= COEF_WIDTH'(ibq_pkg::RST_B0);
      b1_q <= COEF_WIDTH'(ibq_pkg::RST_B1);
      b2_q <= COEF_WIDTH'(ibq_pkg::RST_B2);
      a0_q <= A0_W'(ibq_pkg::RST_A0);
      a1_q <= COEF_WIDTH'(ibq_pkg::RST_A1);
      a2_q <= COEF_WIDTH'(ibq_pkg::RST_A2);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        ibq_pkg::REG_B0: b0_q <= cfg_data_i;
        ibq_pkg::REG_B1: b1_q <= cfg_data_i;
        ibq_pkg::REG_B2: b2_q <= cfg_data_i;
        ibq_pkg::REG_A0: a0_q <= cfg_data_i[A0_W-1:0];
        ibq_pkg::REG_A1: a1_q <= cfg_data_i;
        ibq_pkg::REG_A2: a2_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Select operands of the shared multiplier
  always_comb begin
    unique case (cmd_i.term)
      ibq_pkg::TERM_B0: begin
        op_coef = b0_q; op_data = HW'(x_q);   op_sub = 1'b0;
      end
      ibq_pkg::TERM_B1: begin
        op_coef = b1_q; op_data = HW'(xh1_q); op_sub = 1'b0;
      end
      ibq_pkg::TERM_B2: begin
        op_coef = b2_q; op_data = HW'(xh2_q); op_sub = 1'b0;
      end
      ibq_pkg::TERM_A1: begin
        op_coef = a1_q; op_data = yh1_q;      op_sub = 1'b1;
      end
      ibq_pkg::TERM_A2: begin
        op_coef = a2_q; op_data = yh2_q;      op_sub = 1'b1;
      end
      default: begin
        op_coef = '0;   op_data = '0;         op_sub = 1'b0;
      end
    endcase
  end

  assign prod_d = PROD_W'(op_coef) * PROD_W'(op_data);
  assign acc_d  = prod_sub_q ? (acc_q - ACC_W'(prod_q)) : (acc_q + ACC_W'(prod_q));

  // One restoring division step on the quotient magnitude
  assign div_v = (a0_q == '0) ? A0_W'(1) : a0_q;
  assign trial = {rem_q, dq_q[ACC_W-1]};
  assign diff  = {1'b0, trial} - {2'b00, div_v};
  assign qbit  = ~diff[A0_W+1];

  // Saturate the quotient to history and sample widths
  always_comb begin
    if (!neg_q) begin
      y_sat = (dq_q > Y_POS_MAX) ? {1'b0, {(HW-1){1'b1}}} : dq_q[HW-1:0];
      s_sat = (dq_q > S_POS_MAX) ? {1'b0, {(SAMPLE_WIDTH-1){1'b1}}}
                                 : dq_q[SAMPLE_WIDTH-1:0];
    end else begin
      y_sat = (dq_q > Y_NEG_MAX) ? {1'b1, {(HW-1){1'b0}}}
                                 : HW'(~dq_q[HW-1:0] + HW'(1));
      s_sat = (dq_q > S_NEG_MAX) ? {1'b1, {(SAMPLE_WIDTH-1){1'b0}}}
                                 : SAMPLE_WIDTH'(~dq_q[SAMPLE_WIDTH-1:0] + SAMPLE_WIDTH'(1));
    end
  end

  // Hold filter history
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      xh1_q <= '0;
      xh2_q <= '0;
      yh1_q <= '0;
      yh2_q <= '0;
    end else if (cmd_i.emit) begin
      xh2_q <= xh1_q;
      xh1_q <= x_q;
      yh2_q <= yh1_q;
      yh1_q <= y_sat;
    end
  end

  // Multiply, accumulate and divide
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_x) begin
      x_q <= sample_in_i;
    end
    if (cmd_i.mul) begin
      prod_q     <= prod_d;
      prod_sub_q <= op_sub;
    end
    if (cmd_i.clr_acc) begin
      acc_q <= '0;
    end else if (cmd_i.acc) begin
      acc_q <= acc_d;
    end
    if (cmd_i.div_load) begin
      neg_q <= acc_q[ACC_W-1];
      dq_q  <= acc_q[ACC_W-1] ? ACC_W'(-acc_q) : ACC_W'(acc_q);
      rem_q <= '0;
    end else if (cmd_i.div_step) begin
      rem_q <= qbit ? diff[A0_W-1:0] : trial[A0_W-1:0];
      dq_q  <= {dq_q[ACC_W-2:0], qbit};
    end
    if (cmd_i.emit) begin
      sample_out_o <= s_sat;
    end
  end

endmodule

`default_nettype wire

// ===== design/ibq_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ibq_ctrl #(
  parameter int COEF_WIDTH = ibq_pkg::DEF_COEF_WIDTH
) (
  input  wire            clk_i,
  input  wire            rst_ni,
  input  wire            in_valid_i,
  output logic           in_stall_o,
  output logic           out_valid_o,
  input  wire            out_stall_i,
  output ibq_pkg::cmd_t  cmd_o
);

  localparam int ACC_W = COEF_WIDTH + ibq_pkg::HIST_W + 3;
  localparam int CNT_W = $clog2(ACC_W);
  localparam logic [CNT_W-1:0] MAC_LAST = CNT_W'(ibq_pkg::MAC_TERMS);
  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(ACC_W - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_DIV_LOAD,
    ST_DIV,
    ST_FIN
  } state_e;

  state_e           state_q;
  logic [CNT_W-1:0] cnt_q;
  logic             out_valid_q;
  logic             in_fire;
  logic             out_free;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_fire     = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;

  // Decode datapath commands
  always_comb begin
    cmd_o          = '0;
    cmd_o.term     = ibq_pkg::TERM_B0;
    cmd_o.load_x   = in_fire;
    unique case (state_q)
      ST_MAC: begin
        cmd_o.clr_acc = (cnt_q == '0);
        cmd_o.acc     = (cnt_q != '0);
        cmd_o.mul     = (cnt_q != MAC_LAST);
        unique case (cnt_q)
          CNT_W'(1): cmd_o.term = ibq_pkg::TERM_B1;
          CNT_W'(2): cmd_o.term = ibq_pkg::TERM_B2;
          CNT_W'(3): cmd_o.term = ibq_pkg::TERM_A1;
          CNT_W'(4): cmd_o.term = ibq_pkg::TERM_A2;
          default:   cmd_o.term = ibq_pkg::TERM_B0;
        endcase
      end
      ST_DIV_LOAD: cmd_o.div_load = 1'b1;
      ST_DIV:      cmd_o.div_step = 1'b1;
      ST_FIN:      cmd_o.emit     = out_free;
      default: ;
    endcase
  end

  // Sequence one sample and hold the output transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // Raise valid on a new result, drop it once the transaction completes
      if (cmd_o.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            state_q <= ST_MAC;
            cnt_q   <= '0;
          end
        end
        ST_MAC: begin
          if (cnt_q == MAC_LAST) begin
            state_q <= ST_DIV_LOAD;
          end
          cnt_q <= cnt_q + CNT_W'(1);
        end
        ST_DIV_LOAD: begin
          state_q <= ST_DIV;
          cnt_q   <= '0;
        end
        ST_DIV: begin
          if (cnt_q == DIV_LAST) begin
            state_q <= ST_FIN;
          end
          cnt_q <= cnt_q + CNT_W'(1);
        end
        ST_FIN: begin
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> in_stall_o)
    else $error("input taken while a sample is in progress");

  a_emit_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> (!out_valid_q || !out_stall_i))
    else $error("result written over a stalled output");

  a_emit_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |=> out_valid_q)
    else $error("result written without output valid");

  a_div_excl_mac: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.div_step |-> !(cmd_o.mul || cmd_o.acc || cmd_o.emit))
    else $error("divider step overlaps another datapath command");

endmodule

`default_nettype wire

// ===== design/iir_biquad_integer_filter.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake                 Payload
// config    in         cfg_we_i                  cfg_idx_i, cfg_data_i
// sample    in         in_valid_i / in_stall_o   sample_in_i
// result    out        out_valid_o / out_stall_i sample_out_o
//
// Each accepted sample runs through the shared multiplier and accumulator,
// then the ACC_W-bit restoring divider (ACC_W = COEF_WIDTH + 35) at one
// quotient bit per cycle; no new sample is taken until the block is idle.
// Reset clears the histories and loads the default coefficients. A stalled
// result holds the block in its final step; a sample can be taken while a
// finished result still waits in the output register.

module iir_biquad_integer_filter #(
  parameter int SAMPLE_WIDTH = ibq_pkg::DEF_SAMPLE_WIDTH,
  parameter int COEF_WIDTH   = ibq_pkg::DEF_COEF_WIDTH
) (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  wire                                 cfg_we_i,
  input  wire        [ibq_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire        [COEF_WIDTH-1:0]         cfg_data_i,
  input  wire                                 in_valid_i,
  output logic                                in_stall_o,
  input  wire signed [SAMPLE_WIDTH-1:0]       sample_in_i,
  output logic                                out_valid_o,
  input  wire                                 out_stall_i,
  output logic signed [SAMPLE_WIDTH-1:0]      sample_out_o
);

  ibq_pkg::cmd_t cmd;

  // Sequence the per-sample steps
  ibq_ctrl #(
    .COEF_WIDTH (COEF_WIDTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  // Coefficients, histories, multiplier and divider
  ibq_datapath #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .COEF_WIDTH   (COEF_WIDTH)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .sample_in_i  (sample_in_i),
    .cmd_i        (cmd),
    .sample_out_o (sample_out_o)
  );

endmodule

`default_nettype wire
